[hdl/opws_pkg.sv]
// ----------------------------------------------------------------------------
// opws_pkg
// Shared constants, codes and the setup table of the OLED page write sequencer.
// ----------------------------------------------------------------------------
package opws_pkg;

    localparam int PAGES   = 8;
    localparam int COLUMNS = 128;

    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam int SETUP_LEN     = 20;
    localparam int CONTRAST_SLOT = 13;
    localparam int STEP_W        = $clog2(SETUP_LEN);

    typedef logic [2:0]      mode_t;
    typedef logic [1:0]      wait_t;
    typedef logic [1:0]      cfg_idx_t;
    typedef logic [7:0]      byte_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [COL_W-1:0]  col_t;

    localparam mode_t MODE_PIXEL  = 3'd0;
    localparam mode_t MODE_BRIGHT = 3'd1;
    localparam mode_t MODE_ON     = 3'd2;
    localparam mode_t MODE_OFF    = 3'd3;
    localparam mode_t MODE_INIT   = 3'd4;

    localparam wait_t WAIT_NONE   = 2'd0;
    localparam wait_t WAIT_BEFORE = 2'd1;
    localparam wait_t WAIT_AFTER  = 2'd2;

    localparam cfg_idx_t REG_COLUMN_OFFSET = 2'd0;
    localparam cfg_idx_t REG_INIT_CONTRAST = 2'd1;

    localparam byte_t CMD_PAGE_SEL    = 8'hB0;
    localparam byte_t CMD_COL_HIGH    = 8'h10;
    localparam byte_t CMD_CONTRAST    = 8'h81;
    localparam byte_t CMD_DISPLAY_ON  = 8'hAF;
    localparam byte_t CMD_DISPLAY_OFF = 8'hAE;

    localparam byte_t RST_COLUMN_OFFSET = 8'h02;
    localparam byte_t RST_INIT_CONTRAST = 8'h5C;

    // one write of the controller bus
    typedef struct packed {
        byte_t bus_byte;
        logic  is_data;
        logic  power_on;
        wait_t wait_phase;
        logic  last;
    } res_t;

    function automatic byte_t setup_byte(input step_t idx, input byte_t contrast);
        byte_t b;
        case (idx)
            5'd0:    b = 8'hAE;
            5'd1:    b = 8'hAD;
            5'd2:    b = 8'h8A;
            5'd3:    b = 8'hA8;
            5'd4:    b = 8'h3F;
            5'd5:    b = 8'hD3;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'hA1;
            5'd9:    b = 8'hC8;
            5'd10:   b = 8'hA6;
            5'd11:   b = 8'hA4;
            5'd12:   b = 8'h81;
            5'd13:   b = contrast;
            5'd14:   b = 8'hD5;
            5'd15:   b = 8'h60;
            5'd16:   b = 8'hD8;
            5'd17:   b = 8'h00;
            5'd18:   b = 8'hD9;
            5'd19:   b = 8'h84;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hdl/oled_page_write_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// oled_page_write_sequencer_unit
// Turns pixel bytes and display commands into tagged controller bus writes.
// ----------------------------------------------------------------------------
// One item is held in an input stage and sends one bus write per cycle (while
// the output does not stall) into an output register. A mid-page pixel byte is
// one write, so a new one is then taken every cycle. One at the start of a page
// is 4 writes (page and column header first), set brightness 2, display on or
// off 1 and init 20; the input stalls while the stage still owes writes. Modes
// 5 to 7 are taken and dropped. Page and column advance when the last write of
// an item leaves the stage, and every command returns them to page 0.
module oled_page_write_sequencer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  opws_pkg::mode_t    mode,
    input  opws_pkg::byte_t    value,
    output logic               out_valid,
    input  logic               out_stall,
    output opws_pkg::byte_t    bus_byte,
    output logic               is_data,
    output logic               power_on,
    output opws_pkg::wait_t    wait_phase,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  opws_pkg::cfg_idx_t cfg_index,
    input  opws_pkg::byte_t    cfg_data
);
    import opws_pkg::*;

    byte_t col_offset_reg;
    byte_t contrast_reg;
    page_t page_reg;
    col_t  col_reg;
    logic  conv_reg;

    logic  stage_valid_reg;
    mode_t stage_mode_reg;
    byte_t stage_value_reg;
    step_t step_reg;

    logic  out_valid_reg;
    res_t  out_reg;

    res_t  res;
    logic  advance;
    logic  in_accept;
    logic  hdr;

    assign cfg_ready = 1'b1;

    // pixel byte at column 0 carries the page header
    assign hdr = (col_reg == '0);

    always_comb
    begin
        res            = '0;
        res.power_on   = conv_reg;
        res.wait_phase = WAIT_NONE;
        case (stage_mode_reg)
            MODE_PIXEL:
            begin
                if (hdr && step_reg == 5'd0)
                begin
                    res.bus_byte = CMD_PAGE_SEL + (8'(page_reg) & 8'h0F);
                end
                else if (hdr && step_reg == 5'd1)
                begin
                    res.bus_byte = col_offset_reg & 8'h0F;
                end
                else if (hdr && step_reg == 5'd2)
                begin
                    res.bus_byte = CMD_COL_HIGH | (col_offset_reg >> 4);
                end
                else
                begin
                    res.bus_byte = stage_value_reg;
                    res.is_data  = 1'b1;
                    res.last     = 1'b1;
                end
            end
            MODE_BRIGHT:
            begin
                res.bus_byte = (step_reg == 5'd0) ? CMD_CONTRAST : stage_value_reg;
                res.last     = (step_reg != 5'd0);
            end
            MODE_ON:
            begin
                res.bus_byte   = CMD_DISPLAY_ON;
                res.power_on   = 1'b1;
                res.wait_phase = WAIT_BEFORE;
                res.last       = 1'b1;
            end
            MODE_OFF:
            begin
                res.bus_byte   = CMD_DISPLAY_OFF;
                res.power_on   = 1'b0;
                res.wait_phase = WAIT_AFTER;
                res.last       = 1'b1;
            end
            MODE_INIT:
            begin
                res.bus_byte = setup_byte(step_reg, contrast_reg);
                res.power_on = 1'b0;
                res.last     = (step_reg == step_t'(SETUP_LEN - 1));
            end
            default:
            begin
                res.last = 1'b1;
            end
        endcase
    end

    assign advance   = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = stage_valid_reg && !(advance && res.last);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_offset_reg <= RST_COLUMN_OFFSET;
            contrast_reg   <= RST_INIT_CONTRAST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLUMN_OFFSET: col_offset_reg <= cfg_data;
                REG_INIT_CONTRAST: contrast_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            step_reg        <= '0;
            page_reg        <= '0;
            col_reg         <= '0;
            conv_reg        <= 1'b0;
        end
        else
        begin
            // unused modes are taken and dropped
            if (in_accept && mode <= MODE_INIT)
            begin
                stage_valid_reg <= 1'b1;
                step_reg        <= '0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + step_t'(1);
                if (res.last)
                begin
                    stage_valid_reg <= 1'b0;
                end
            end
            if (advance && res.last)
            begin
                conv_reg <= res.power_on;
                if (stage_mode_reg == MODE_PIXEL)
                begin
                    if (col_reg == col_t'(COLUMNS - 1))
                    begin
                        col_reg  <= '0;
                        page_reg <= (page_reg == page_t'(PAGES - 1)) ?
                                    '0 : page_reg + page_t'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + col_t'(1);
                    end
                end
                else
                begin
                    col_reg  <= '0;
                    page_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_mode_reg  <= mode;
            stage_value_reg <= value;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bus_byte   = out_reg.bus_byte;
    assign is_data    = out_reg.is_data;
    assign power_on   = out_reg.power_on;
    assign wait_phase = out_reg.wait_phase;
    assign last       = out_reg.last;

`ifndef SYNTHESIS
    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> !in_stall)
        else $error("input stalled with an empty stage");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= col_t'(COLUMNS - 1))
        else $error("column counter out of range");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> step_reg < step_t'(SETUP_LEN))
        else $error("write step out of range");

    a_on_sets_conv: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.last && stage_mode_reg == MODE_ON |=> conv_reg)
        else $error("converter not enabled after display on");

    a_data_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_data |-> out_reg.wait_phase == WAIT_NONE
            && out_reg.last)
        else $error("data write with wait or not last");
`endif

endmodule
